// ===== src/hlc_pkg.sv =====
// hlc_pkg: shared types, constants and single-precision float helpers
// for the homogeneous line clipper; no dependencies
`default_nettype none

package hlc_pkg;

  // float constants
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F_HALF    = 32'h3F00_0000;
  localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;
  localparam logic [30:0] F_EPS_MAG = 31'h3586_37BD;

  // pipeline geometry
  localparam int DIV_NQ     = 27;
  localparam int DIV_LAT    = DIV_NQ + 2;
  localparam int PLANE_LAT  = DIV_LAT + 4;
  localparam int PROJ_LAT   = DIV_LAT + 5;
  localparam int NUM_PLANES = 6;
  localparam int PIPE_LAT   = 2 + NUM_PLANES * PLANE_LAT + PROJ_LAT;

  typedef enum logic [2:0] {
    PL_XP, PL_XN, PL_YP, PL_YN, PL_ZP, PL_ZN
  } plane_t;

  typedef enum logic [2:0] {
    REG_ENABLED, REG_LEFT, REG_TOP, REG_WIDTH, REG_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } hvec_t;

  typedef struct packed {
    logic  alive;
    hvec_t a;
    hvec_t b;
  } seg_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] top;
    logic [31:0] width;
    logic [31:0] height;
  } vport_t;

  typedef struct packed {
    logic        alive;
    logic [31:0] sax;
    logic [31:0] say;
    logic [31:0] sbx;
    logic [31:0] sby;
  } res_t;

  typedef struct packed {
    logic [23:0]        m;
    logic signed [11:0] e;
  } unp_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sgn;
    logic signed [11:0] e;
    logic [24:0]        r;
    logic [23:0]        d;
    logic [DIV_NQ-1:0]  q;
  } divst_t;

  // classification
  function automatic logic f_isnan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic f_isinf(input logic [31:0] a);
    return a[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic f_iszero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic f_isneg(input logic [31:0] a);
    return a[31] && !f_iszero(a) && !f_isnan(a);
  endfunction

  function automatic logic f_small(input logic [31:0] a);
    return a[30:0] < F_EPS_MAG;
  endfunction

  function automatic logic [31:0] f_neg(input logic [31:0] a);
    return {~a[31], a[30:0]};
  endfunction

  function automatic logic [31:0] f_canon(input logic [31:0] a);
    return f_isnan(a) ? F_QNAN : a;
  endfunction

  // leading zero counts
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // mantissa with leading one at bit 23, subnormals normalized
  function automatic unp_t f_unpack(input logic [31:0] a);
    unp_t        u;
    logic [4:0]  lz;
    logic [23:0] m;
    m = {a[30:23] != 8'd0, a[22:0]};
    lz = lzc24(m);
    u.m = m << lz;
    u.e = ((a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]}))
          - $signed({7'd0, lz});
    return u;
  endfunction

  // round to nearest even; m has its leading one at bit 27, sticky in bit 0
  function automatic logic [31:0] f_round(input logic s, input logic signed [11:0] e,
                                          input logic [27:0] m);
    logic [27:0] ms;
    logic [27:0] mask;
    logic [7:0]  ef;
    logic [11:0] sh;
    logic        inc;
    logic [30:0] mag;
    if (e >= 12'sd255) return {s, 8'hFF, 23'd0};
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh > 12'd27) begin
        ms = {27'd0, |m};
      end else begin
        mask = ~(28'hFFF_FFFF << sh[4:0]);
        ms = (m >> sh[4:0]) | {27'd0, |(m & mask)};
      end
      ef = 8'd0;
    end else begin
      ms = m;
      ef = e[7:0];
    end
    inc = ms[3] & ((|ms[2:0]) | ms[4]);
    mag = {ef, ms[26:4]} + {30'd0, inc};
    return {s, mag};
  endfunction

  // single-precision add
  function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x;
    logic [31:0]        y;
    logic [23:0]        mx;
    logic [23:0]        my;
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [7:0]         dd;
    logic [4:0]         sha;
    logic [53:0]        yw;
    logic [26:0]        xa;
    logic [26:0]        ya;
    logic [27:0]        sum;
    logic [4:0]         lz;
    logic signed [11:0] e;
    if (f_isnan(a) || f_isnan(b)) return F_QNAN;
    if (f_isinf(a) && f_isinf(b) && (a[31] != b[31])) return F_QNAN;
    if (f_isinf(a)) return a;
    if (f_isinf(b)) return b;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    dd = ex - ey;
    sha = (dd > 8'd31) ? 5'd31 : dd[4:0];
    yw = {my, 30'd0} >> sha;
    ya = {yw[53:28], yw[27] | (|yw[26:0])};
    xa = {mx, 3'd0};
    if (x[31] == y[31]) sum = {1'b0, xa} + {1'b0, ya};
    else sum = {1'b0, xa} - {1'b0, ya};
    if (sum == 28'd0) return {x[31] & y[31], 31'd0};
    lz = lzc28(sum);
    e = $signed({4'd0, ex}) + 12'sd1 - $signed({7'd0, lz});
    return f_round(x[31], e, sum << lz);
  endfunction

  // single-precision multiply
  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    unp_t               ua;
    unp_t               ub;
    logic [47:0]        p;
    logic signed [11:0] e;
    logic [27:0]        m;
    s = a[31] ^ b[31];
    if (f_isnan(a) || f_isnan(b)) return F_QNAN;
    if ((f_isinf(a) && f_iszero(b)) || (f_iszero(a) && f_isinf(b))) return F_QNAN;
    if (f_isinf(a) || f_isinf(b)) return {s, 8'hFF, 23'd0};
    if (f_iszero(a) || f_iszero(b)) return {s, 31'd0};
    ua = f_unpack(a);
    ub = f_unpack(b);
    p = ua.m * ub.m;
    e = ua.e + ub.e - 12'sd127;
    if (p[47]) begin
      m = {p[47:21], |p[20:0]};
      e = e + 12'sd1;
    end else begin
      m = {p[46:20], |p[19:0]};
    end
    return f_round(s, e, m);
  endfunction

  // divider front end: special cases and operand alignment
  function automatic divst_t f_div_prep(input logic [31:0] n, input logic [31:0] dv);
    divst_t st;
    unp_t   un;
    unp_t   ud;
    st.sgn  = n[31] ^ dv[31];
    st.spec = 1'b1;
    st.sval = {st.sgn, 31'd0};
    st.e    = 12'sd0;
    st.r    = '0;
    st.d    = '0;
    st.q    = '0;
    un = f_unpack(n);
    ud = f_unpack(dv);
    if (f_isnan(n) || f_isnan(dv) || (f_isinf(n) && f_isinf(dv)) ||
        (f_iszero(n) && f_iszero(dv))) begin
      st.sval = F_QNAN;
    end else if (f_isinf(n) || f_iszero(dv)) begin
      st.sval = {st.sgn, 8'hFF, 23'd0};
    end else if (f_iszero(n) || f_isinf(dv)) begin
      st.sval = {st.sgn, 31'd0};
    end else begin
      st.spec = 1'b0;
      st.d = ud.m;
      st.e = un.e - ud.e + 12'sd127;
      if (un.m < ud.m) begin
        st.r = {un.m, 1'b0};
        st.e = st.e - 12'sd1;
      end else begin
        st.r = {1'b0, un.m};
      end
    end
    return st;
  endfunction

  // one restoring quotient bit
  function automatic divst_t f_div_step(input divst_t si);
    divst_t so;
    so = si;
    if (si.r >= {1'b0, si.d}) begin
      so.q = {si.q[DIV_NQ-2:0], 1'b1};
      so.r = (si.r - {1'b0, si.d}) << 1;
    end else begin
      so.q = {si.q[DIV_NQ-2:0], 1'b0};
      so.r = si.r << 1;
    end
    return so;
  endfunction

  function automatic logic [31:0] f_div_finish(input divst_t st);
    return st.spec ? st.sval : f_round(st.sgn, st.e, {st.q, st.r != 25'd0});
  endfunction

  // component-wise helpers
  function automatic hvec_t hv_sub(input hvec_t b, input hvec_t a);
    hvec_t r;
    r.x = f_add(b.x, f_neg(a.x));
    r.y = f_add(b.y, f_neg(a.y));
    r.z = f_add(b.z, f_neg(a.z));
    r.w = f_add(b.w, f_neg(a.w));
    return r;
  endfunction

  function automatic hvec_t hv_scale(input hvec_t d, input logic [31:0] t);
    hvec_t r;
    r.x = f_mul(d.x, t);
    r.y = f_mul(d.y, t);
    r.z = f_mul(d.z, t);
    r.w = f_mul(d.w, t);
    return r;
  endfunction

  function automatic hvec_t hv_add(input hvec_t a, input hvec_t m);
    hvec_t r;
    r.x = f_add(a.x, m.x);
    r.y = f_add(a.y, m.y);
    r.z = f_add(a.z, m.z);
    r.w = f_add(a.w, m.w);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/hlc_div.sv =====
// hlc_div: pipelined single-precision divider, one quotient bit per stage,
// several lanes and a side payload that travels along; uses hlc_pkg
`default_nettype none

module hlc_div import hlc_pkg::*; #(
  parameter int NL = 1,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic [NL-1:0][31:0]  num_i,
  input  logic [NL-1:0][31:0]  den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic [NL-1:0][31:0]  quo_o,
  output logic [SW-1:0]        side_o
);

  divst_t              st_r   [DIV_NQ+1][NL];
  logic [SW-1:0]       side_r [DIV_NQ+1];
  logic [DIV_NQ:0]     vld_r;
  logic [NL-1:0][31:0] quo_r;
  logic [SW-1:0]       sout_r;
  logic                vout_r;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vout_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[DIV_NQ-1:0], vld_i};
      vout_r <= vld_r[DIV_NQ];
    end
  end

  // recurrence stages
  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) begin
      st_r[0][l] <= f_div_prep(num_i[l], den_i[l]);
      for (int k = 0; k < DIV_NQ; k++) begin
        st_r[k+1][l] <= f_div_step(st_r[k][l]);
      end
      quo_r[l] <= f_div_finish(st_r[DIV_NQ][l]);
    end
    side_r[0] <= side_i;
    for (int k = 0; k < DIV_NQ; k++) begin
      side_r[k+1] <= side_r[k];
    end
    sout_r <= side_r[DIV_NQ];
  end

  assign vld_o  = vout_r;
  assign quo_o  = quo_r;
  assign side_o = sout_r;

endmodule

`default_nettype wire

// ===== src/hlc_plane.sv =====
// hlc_plane: one clip cell of the chain, clips a segment against one plane
// and hands it to the next cell; uses hlc_pkg and hlc_div
`default_nettype none

module hlc_plane import hlc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  plane_t plane,
  input  logic   vld_i,
  input  seg_t   seg_i,
  output logic   vld_o,
  output seg_t   seg_o
);

  typedef struct packed {
    logic  alive;
    logic  na;
    logic  nb;
    hvec_t a;
    hvec_t b;
    hvec_t d;
  } pside_t;

  logic [31:0] ca;
  logic [31:0] cb;
  logic        neg;
  logic [31:0] fa_r;
  logic [31:0] fb_r;
  hvec_t       d_r;
  seg_t        seg1_r;
  logic        vld1_r;
  logic        na;
  logic        nb;
  logic [31:0] num_r;
  logic [31:0] den_r;
  pside_t      side2_r;
  logic        vld2_r;
  logic        dvld;
  logic [31:0] t;
  pside_t      dside;
  hvec_t       m_r;
  pside_t      side3_r;
  logic        vld3_r;
  hvec_t       p;
  seg_t        seg_nxt;
  seg_t        seg_r;
  logic        vld4_r;

  // coordinate of this plane
  always_comb begin
    case (plane)
      PL_XP, PL_XN: begin
        ca = seg_i.a.x;
        cb = seg_i.b.x;
      end
      PL_YP, PL_YN: begin
        ca = seg_i.a.y;
        cb = seg_i.b.y;
      end
      default: begin
        ca = seg_i.a.z;
        cb = seg_i.b.z;
      end
    endcase
  end

  assign neg = (plane == PL_XN) || (plane == PL_YN) || (plane == PL_ZN);

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= dvld;
      vld4_r <= vld3_r;
    end
  end

  // distances to the plane and endpoint difference
  always_ff @(posedge clk) begin
    fa_r   <= f_add(seg_i.a.w, {ca[31] ^ neg, ca[30:0]});
    fb_r   <= f_add(seg_i.b.w, {cb[31] ^ neg, cb[30:0]});
    d_r    <= hv_sub(seg_i.b, seg_i.a);
    seg1_r <= seg_i;
  end

  assign na = f_isneg(fa_r);
  assign nb = f_isneg(fb_r);

  // denominator of the crossing parameter
  always_ff @(posedge clk) begin
    num_r         <= fa_r;
    den_r         <= f_add(fa_r, f_neg(fb_r));
    side2_r.alive <= seg1_r.alive && !(na && nb);
    side2_r.na    <= na;
    side2_r.nb    <= nb;
    side2_r.a     <= seg1_r.a;
    side2_r.b     <= seg1_r.b;
    side2_r.d     <= d_r;
  end

  hlc_div #(
    .NL (1),
    .SW ($bits(pside_t))
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld2_r),
    .num_i  (num_r),
    .den_i  (den_r),
    .side_i (side2_r),
    .vld_o  (dvld),
    .quo_o  (t),
    .side_o (dside)
  );

  // scaled difference
  always_ff @(posedge clk) begin
    m_r     <= hv_scale(dside.d, t);
    side3_r <= dside;
  end

  // move the outside endpoint
  always_comb begin
    p = hv_add(side3_r.a, m_r);
    seg_nxt.alive = side3_r.alive;
    seg_nxt.a     = side3_r.na ? p : side3_r.a;
    seg_nxt.b     = (side3_r.nb && !side3_r.na) ? p : side3_r.b;
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign vld_o = vld4_r;
  assign seg_o = seg_r;

endmodule

`default_nettype wire

// ===== src/hlc_proj.sv =====
// hlc_proj: perspective divide and viewport mapping of a clipped segment;
// uses hlc_pkg and hlc_div
`default_nettype none

module hlc_proj import hlc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_i,
  input  seg_t   seg_i,
  input  vport_t vp,
  output logic   vld_o,
  output res_t   res_o
);

  logic [3:0][31:0] num;
  logic [3:0][31:0] den;
  logic             keep;
  logic             dvld;
  logic [3:0][31:0] quo;
  logic             dalive;
  logic [3:0][31:0] h_r;
  logic [3:0][31:0] q_r;
  logic [3:0][31:0] r_r;
  logic [3:0][31:0] r2_r;
  logic [3:0][31:0] s_r;
  logic [4:0]       vld_r;
  logic [4:0]       alive_r;

  // lanes: start x, start y, end x, end y
  assign num  = {seg_i.b.y, seg_i.b.x, seg_i.a.y, seg_i.a.x};
  assign den  = {seg_i.b.w, seg_i.b.w, seg_i.a.w, seg_i.a.w};
  assign keep = seg_i.alive && !f_small(seg_i.a.w) && !f_small(seg_i.b.w);

  hlc_div #(
    .NL (4),
    .SW (1)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_i),
    .num_i  (num),
    .den_i  (den),
    .side_i (keep),
    .vld_o  (dvld),
    .quo_o  (quo),
    .side_o (dalive)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], dvld};
    end
  end

  // mapping stages, x lanes even and y lanes odd
  always_ff @(posedge clk) begin
    alive_r <= {alive_r[3:0], dalive};
    for (int l = 0; l < 4; l++) begin
      h_r[l] <= f_add(quo[l], F_ONE);
      q_r[l] <= f_mul(h_r[l], F_HALF);
      if (l % 2 == 0) begin
        r_r[l]  <= f_mul(q_r[l], vp.width);
        r2_r[l] <= r_r[l];
        s_r[l]  <= f_add(vp.left, r2_r[l]);
      end else begin
        r_r[l]  <= f_add(F_ONE, f_neg(q_r[l]));
        r2_r[l] <= f_mul(r_r[l], vp.height);
        s_r[l]  <= f_add(vp.top, r2_r[l]);
      end
    end
  end

  assign vld_o       = vld_r[4];
  assign res_o.alive = alive_r[4];
  assign res_o.sax   = s_r[0];
  assign res_o.say   = s_r[1];
  assign res_o.sbx   = s_r[2];
  assign res_o.sby   = s_r[3];

endmodule

`default_nettype wire

// ===== src/homogeneous_line_clip_to_screen.sv =====
// homogeneous_line_clip_to_screen: top level, register port, chain of six
// clip cells and the projection stage; uses hlc_pkg, hlc_plane, hlc_proj
`default_nettype none

// Clips one line segment in homogeneous clip space against the six view
// planes and maps the survivor to the viewport.
// Input: a transaction is taken at each rising edge with start high and busy
// low; busy stays low, so one segment can enter in every cycle.
// Output: out_valid marks each result for exactly one cycle. The result of a
// transaction passes through an input register, six clip cells of 33 stages
// each, a 34-stage projection and an output register. Throughput is one
// segment per cycle: every cell is fully pipelined, the dividers resolve one
// quotient bit per stage and each float add or multiply has its own register.
// Registers over APB: viewport enable, left, top, width, height at byte
// addresses 0, 4, 8, 12, 16; write only while no transaction is in flight.
// Reset clears the registers and drains the pipeline; transactions in flight
// are dropped. The receiver has no back pressure and must take every result.
// Invisible results carry zero coordinates.

module homogeneous_line_clip_to_screen import hlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_start_z,
  input  logic [31:0] in_start_w,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic [31:0] in_end_z,
  input  logic [31:0] in_end_w,
  output logic        out_valid,
  output logic        out_visible,
  output logic [31:0] out_screen_start_x,
  output logic [31:0] out_screen_start_y,
  output logic [31:0] out_screen_end_x,
  output logic [31:0] out_screen_end_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     en_r;
  vport_t   vp_r;
  logic     wr_en;
  reg_idx_t ridx;
  logic     vp_ok;
  logic     in_vld_r;
  seg_t     in_seg_r;
  logic     vld_w [NUM_PLANES+1];
  seg_t     seg_w [NUM_PLANES+1];
  logic     pvld;
  res_t     pres;
  logic     vis;
  logic     out_vld_r;
  logic     out_vis_r;
  logic [31:0] out_sax_r;
  logic [31:0] out_say_r;
  logic [31:0] out_sbx_r;
  logic [31:0] out_sby_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
      vp_r <= '0;
    end else if (wr_en) begin
      case (ridx)
        REG_ENABLED: en_r        <= pwdata[0];
        REG_LEFT:    vp_r.left   <= pwdata;
        REG_TOP:     vp_r.top    <= pwdata;
        REG_WIDTH:   vp_r.width  <= pwdata;
        REG_HEIGHT:  vp_r.height <= pwdata;
        default:     ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      REG_ENABLED: prdata = {31'd0, en_r};
      REG_LEFT:    prdata = vp_r.left;
      REG_TOP:     prdata = vp_r.top;
      REG_WIDTH:   prdata = vp_r.width;
      REG_HEIGHT:  prdata = vp_r.height;
      default:     prdata = 32'd0;
    endcase
  end

  assign vp_ok = en_r &&
                 !f_iszero(vp_r.width)  && !f_isneg(vp_r.width) &&
                 !f_iszero(vp_r.height) && !f_isneg(vp_r.height);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_seg_r.alive <= 1'b1;
    in_seg_r.a     <= {in_start_x, in_start_y, in_start_z, in_start_w};
    in_seg_r.b     <= {in_end_x, in_end_y, in_end_z, in_end_w};
  end

  assign vld_w[0] = in_vld_r;
  assign seg_w[0] = in_seg_r;

  // chain of clip cells
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
    hlc_plane u_plane (
      .clk   (clk),
      .rst_n (rst_n),
      .plane (plane_t'(3'(i))),
      .vld_i (vld_w[i]),
      .seg_i (seg_w[i]),
      .vld_o (vld_w[i+1]),
      .seg_o (seg_w[i+1])
    );
  end

  hlc_proj u_proj (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_w[NUM_PLANES]),
    .seg_i (seg_w[NUM_PLANES]),
    .vp    (vp_r),
    .vld_o (pvld),
    .res_o (pres)
  );

  // output register
  assign vis = pres.alive && vp_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= pvld;
    end
  end

  always_ff @(posedge clk) begin
    out_vis_r <= vis;
    out_sax_r <= vis ? f_canon(pres.sax) : 32'd0;
    out_say_r <= vis ? f_canon(pres.say) : 32'd0;
    out_sbx_r <= vis ? f_canon(pres.sbx) : 32'd0;
    out_sby_r <= vis ? f_canon(pres.sby) : 32'd0;
  end

  assign out_valid          = out_vld_r;
  assign out_visible        = out_vis_r;
  assign out_screen_start_x = out_sax_r;
  assign out_screen_start_y = out_say_r;
  assign out_screen_end_x   = out_sbx_r;
  assign out_screen_end_y   = out_sby_r;

endmodule

`default_nettype wire

// ===== src/hlc_chk.sv =====
// hlc_chk: port-level checker for the line clipper and its bind to the top
// level; uses hlc_pkg
`default_nettype none

module hlc_chk import hlc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_visible,
  input logic [31:0] out_screen_start_x,
  input logic [31:0] out_screen_start_y,
  input logic [31:0] out_screen_end_x,
  input logic [31:0] out_screen_end_y
);

  // every accepted transaction yields a result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted transaction produced no result");

  // no result without a matching accepted transaction
  a_lat_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, PIPE_LAT))
    else $error("result without accepted transaction");

  // invisible results carry zero coordinates
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_visible) |->
      (out_screen_start_x == 32'd0) && (out_screen_start_y == 32'd0) &&
      (out_screen_end_x == 32'd0) && (out_screen_end_y == 32'd0))
    else $error("invisible result with nonzero coordinates");

endmodule

bind homogeneous_line_clip_to_screen hlc_chk u_chk (.*);

`default_nettype wire

// ===== tb/sv/hlc_scoreboard.sv =====
// hlc_scoreboard: watches the segment, result and register channels of the line
// clipper, predicts every result in single-precision arithmetic and compares
// depends on hlc_pkg for constants and register indexes
`timescale 1ns / 1ps

module hlc_scoreboard import hlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_start_z,
  input  logic [31:0] in_start_w,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic [31:0] in_end_z,
  input  logic [31:0] in_end_w,
  input  logic        out_valid,
  input  logic        out_visible,
  input  logic [31:0] out_screen_start_x,
  input  logic [31:0] out_screen_start_y,
  input  logic [31:0] out_screen_end_x,
  input  logic [31:0] out_screen_end_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);

  // magnitude bits of 1e-6f
  localparam logic [30:0] W_MIN_MAG = 31'h3586_37BD;

  typedef struct {
    logic        vis;
    logic [31:0] sax;
    logic [31:0] say;
    logic [31:0] sbx;
    logic [31:0] sby;
  } screen_seg_t;

  screen_seg_t expected_segs[$];

  logic        vp_en;
  logic [31:0] vp_left;
  logic [31:0] vp_top;
  logic [31:0] vp_width;
  logic [31:0] vp_height;

  assign pending = expected_segs.size();

  // float classification on bit patterns
  function automatic logic is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return a[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == 0;
  endfunction

  function automatic logic below_zero(input logic [31:0] a);
    return a[31] && !is_zero(a) && !is_nan(a);
  endfunction

  // exact widening of a single to double
  function automatic real widen(input logic [31:0] a);
    real r;
    if (a[30:23] == 0) begin
      r = real'(a[22:0]) * (2.0 ** -149);
      return a[31] ? -r : r;
    end
    return $bitstoreal({a[31], {3'd0, a[30:23]} + 11'd896, a[22:0], 29'd0});
  endfunction

  // double to single, round to nearest even, subnormals and overflow included
  function automatic logic [31:0] narrow(input real r);
    logic [63:0] d;
    logic [63:0] mm;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int          es;
    int          sh;
    logic        inc;
    d = $realtobits(r);
    if (d[62:0] == 0) return {d[63], 31'd0};
    es = int'(d[62:52]) - 1023 + 127;
    mm = {11'd0, 1'b1, d[51:0]};
    sh = (es >= 1) ? 29 : 29 + 1 - es;
    if (sh > 60) return {d[63], 31'd0};
    kept = mm >> sh;
    rem = mm & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    inc = (rem > half) || (rem == half && kept[0]);
    kept = kept + {63'd0, inc};
    if (es >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        es++;
      end
      if (es >= 255) return {d[63], 8'hFF, 23'd0};
      return {d[63], es[7:0], kept[22:0]};
    end
    return {d[63], kept[30:0]};
  endfunction

  // single ops: specials by hand, finite values through a double (one rounding)
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    real r;
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    r = widen(a) + widen(b);
    if (r == 0.0) return {a[31] & b[31], 31'd0};
    return narrow(r);
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    return fadd(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F_QNAN;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return F_QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    return narrow(widen(a) * widen(b));
  endfunction

  function automatic logic [31:0] fdiv(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b)))
      return F_QNAN;
    if (is_inf(a) || is_zero(b)) return {s, 8'hFF, 23'd0};
    if (is_zero(a) || is_inf(b)) return {s, 31'd0};
    return narrow(widen(a) / widen(b));
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] a);
    return is_nan(a) ? F_QNAN : a;
  endfunction

  // clip against six planes, then project both ends to the viewport
  function automatic screen_seg_t clip_and_map(input logic [31:0] pa[4],
                                               input logic [31:0] pb[4]);
    screen_seg_t r;
    logic [31:0] ea[4];
    logic [31:0] eb[4];
    logic [31:0] lp[4];
    logic [31:0] fa;
    logic [31:0] fb;
    logic [31:0] t;
    logic [31:0] q;
    logic        na;
    logic        nb;
    int          ax;
    r = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
    if (!vp_en) return r;
    if (!is_nan(vp_width) && (vp_width[31] || is_zero(vp_width))) return r;
    if (!is_nan(vp_height) && (vp_height[31] || is_zero(vp_height))) return r;
    ea = pa;
    eb = pb;
    for (int p = 0; p < 6; p++) begin
      ax = p / 2;
      if (p % 2 == 0) begin
        fa = fadd(ea[ax], ea[3]);
        fb = fadd(eb[ax], eb[3]);
      end else begin
        fa = fsub(ea[3], ea[ax]);
        fb = fsub(eb[3], eb[ax]);
      end
      na = below_zero(fa);
      nb = below_zero(fb);
      if (na && nb) return r;
      if (na || nb) begin
        t = fdiv(fa, fsub(fa, fb));
        for (int c = 0; c < 4; c++)
          lp[c] = fadd(ea[c], fmul(fsub(eb[c], ea[c]), t));
        if (na) ea = lp;
        else eb = lp;
      end
    end
    if (!is_nan(ea[3]) && ea[3][30:0] < W_MIN_MAG) return r;
    if (!is_nan(eb[3]) && eb[3][30:0] < W_MIN_MAG) return r;
    r.vis = 1'b1;
    q = fmul(fadd(fdiv(ea[0], ea[3]), F_ONE), F_HALF);
    r.sax = canon(fadd(vp_left, fmul(q, vp_width)));
    q = fmul(fadd(fdiv(ea[1], ea[3]), F_ONE), F_HALF);
    r.say = canon(fadd(vp_top, fmul(fsub(F_ONE, q), vp_height)));
    q = fmul(fadd(fdiv(eb[0], eb[3]), F_ONE), F_HALF);
    r.sbx = canon(fadd(vp_left, fmul(q, vp_width)));
    q = fmul(fadd(fdiv(eb[1], eb[3]), F_ONE), F_HALF);
    r.sby = canon(fadd(vp_top, fmul(fsub(F_ONE, q), vp_height)));
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial fails = 0;

  // register writes, accepted transactions and results, all sampled at the edge
  always @(posedge clk) begin
    logic [31:0] pa[4];
    logic [31:0] pb[4];
    screen_seg_t w;
    if (!rst_n) begin
      expected_segs.delete();
      vp_en <= 1'b0;
      vp_left <= '0;
      vp_top <= '0;
      vp_width <= '0;
      vp_height <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_ENABLED: vp_en <= pwdata[0];
          REG_LEFT:    vp_left <= pwdata;
          REG_TOP:     vp_top <= pwdata;
          REG_WIDTH:   vp_width <= pwdata;
          REG_HEIGHT:  vp_height <= pwdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        pa = '{in_start_x, in_start_y, in_start_z, in_start_w};
        pb = '{in_end_x, in_end_y, in_end_z, in_end_w};
        expected_segs.insert(expected_segs.size(), clip_and_map(pa, pb));
      end
      if (out_valid) begin
        if (expected_segs.size() == 0) begin
          report("unexpected result", {31'd0, out_visible}, 32'd0);
        end else begin
          w = expected_segs.pop_front();
          if (out_visible !== w.vis) report("visible", {31'd0, out_visible}, {31'd0, w.vis});
          if (out_screen_start_x !== w.sax) report("screen_start_x", out_screen_start_x, w.sax);
          if (out_screen_start_y !== w.say) report("screen_start_y", out_screen_start_y, w.say);
          if (out_screen_end_x !== w.sbx) report("screen_end_x", out_screen_end_x, w.sbx);
          if (out_screen_end_y !== w.sby) report("screen_end_y", out_screen_end_y, w.sby);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_homogeneous_line_clip_to_screen.sv =====
// tb_homogeneous_line_clip_to_screen: clock, reset, register phases and segment
// stimulus for the line clipper; depends on hlc_pkg and hlc_scoreboard
`timescale 1ns / 1ps

module tb_homogeneous_line_clip_to_screen import hlc_pkg::*;;

  localparam int MAX_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_start_x = '0;
  logic [31:0] in_start_y = '0;
  logic [31:0] in_start_z = '0;
  logic [31:0] in_start_w = '0;
  logic [31:0] in_end_x = '0;
  logic [31:0] in_end_y = '0;
  logic [31:0] in_end_z = '0;
  logic [31:0] in_end_w = '0;
  logic        out_valid;
  logic        out_visible;
  logic [31:0] out_screen_start_x;
  logic [31:0] out_screen_start_y;
  logic [31:0] out_screen_end_x;
  logic [31:0] out_screen_end_y;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          cycles = 0;

  always #5 clk = ~clk;

  homogeneous_line_clip_to_screen DUT (.*);

  hlc_scoreboard checker_i (.*);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic ok;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
      if (ok) break;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_viewport(input logic en, input logic [31:0] l, input logic [31:0] t,
                              input logic [31:0] w, input logic [31:0] h);
    while (pending != 0) @(posedge clk);
    reg_write(REG_ENABLED, {31'd0, en});
    reg_write(REG_LEFT, l);
    reg_write(REG_TOP, t);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // one segment transaction; start stays high into the next one
  task automatic send_seg(input logic [31:0] s[8]);
    logic ok;
    start <= 1'b1;
    {in_start_x, in_start_y, in_start_z, in_start_w} <= {s[0], s[1], s[2], s[3]};
    {in_end_x, in_end_y, in_end_z, in_end_w} <= {s[4], s[5], s[6], s[7]};
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // mostly moderate clip-space values, with specials and raw bit patterns
  function automatic logic [31:0] rand_coord(input logic is_w);
    int k;
    k = $urandom_range(99);
    if (k < 72) return {is_w ? ($urandom_range(9) == 0) : 1'($urandom),
                        8'($urandom_range(131, 118)), 23'($urandom)};
    if (k < 76) return {1'($urandom), 31'd0};
    if (k < 79) return {1'($urandom), 8'hFF, 23'd0};
    if (k < 81) return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
    if (k < 84) return {1'($urandom), 8'd0, 23'($urandom)};
    if (k < 88) return {1'($urandom), 8'($urandom_range(112, 100)), 23'($urandom)};
    return $urandom;
  endfunction

  task automatic random_items(input int n, input int quiet_from, input int quiet_to);
    logic [31:0] s[8];
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < 8; c++) s[c] = rand_coord(c % 4 == 3);
      if ($urandom_range(9) < 2) s[4 + $urandom_range(3)] = s[$urandom_range(3)];
      send_seg(s);
      if ((i < quiet_from || i > quiet_to) && $urandom_range(99) < 33) begin
        repeat ($urandom_range(3, 1)) idle_cycle();
      end
    end
    idle_cycle();
  endtask

  localparam logic [31:0] P2 = 32'h4000_0000;
  localparam logic [31:0] N2 = 32'hC000_0000;
  localparam logic [31:0] PH = 32'h3F00_0000;
  localparam logic [31:0] NH = 32'hBF00_0000;
  localparam logic [31:0] Z0 = 32'h0000_0000;
  localparam logic [31:0] PINF = 32'h7F80_0000;
  localparam logic [31:0] NINF = 32'hFF80_0000;
  localparam logic [31:0] QN = 32'h7FC0_0001;

  logic [31:0] directed[20][8] = '{
    '{NH, NH, NH, F_ONE, PH, PH, PH, F_ONE},       // wholly inside
    '{P2, Z0, Z0, F_ONE, 32'h4040_0000, Z0, Z0, F_ONE}, // outside right
    '{N2, Z0, Z0, F_ONE, PH, Z0, Z0, F_ONE},        // crosses left plane
    '{Z0, Z0, Z0, F_ONE, P2, Z0, Z0, F_ONE},        // crosses right plane
    '{Z0, N2, Z0, F_ONE, Z0, PH, Z0, F_ONE},        // crosses bottom plane
    '{Z0, Z0, Z0, F_ONE, Z0, P2, Z0, F_ONE},        // crosses top plane
    '{Z0, Z0, N2, F_ONE, Z0, Z0, PH, F_ONE},        // crosses near plane
    '{Z0, Z0, Z0, F_ONE, Z0, Z0, P2, F_ONE},        // crosses far plane
    '{N2, N2, N2, F_ONE, P2, P2, P2, F_ONE},        // both ends clipped
    '{Z0, Z0, Z0, 32'h3400_0000, Z0, Z0, Z0, F_ONE}, // tiny w
    '{Z0, Z0, Z0, Z0, Z0, Z0, Z0, 32'h8000_0000},   // zero w both
    '{QN, Z0, Z0, F_ONE, Z0, Z0, Z0, F_ONE},        // nan x
    '{Z0, Z0, Z0, QN, Z0, Z0, Z0, F_ONE},           // nan w
    '{PINF, Z0, Z0, F_ONE, Z0, Z0, Z0, F_ONE},      // infinite x
    '{Z0, Z0, Z0, PINF, Z0, Z0, Z0, F_ONE},         // infinite w
    '{NINF, NINF, NINF, NINF, PINF, PINF, PINF, PINF},
    '{32'h0000_0001, Z0, Z0, F_ONE, Z0, 32'h8000_0001, Z0, F_ONE},
    '{32'h7F7F_FFFF, Z0, Z0, 32'h7F7F_FFFF, Z0, Z0, Z0, F_ONE},
    '{Z0, Z0, Z0, 32'hBF80_0000, Z0, Z0, Z0, 32'hBF80_0000}, // negative w
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset viewport: everything invisible
    for (int i = 0; i < 4; i++) send_seg(directed[i]);
    idle_cycle();

    // typical 640x480 viewport
    set_viewport(1'b1, Z0, Z0, 32'h4420_0000, 32'h43F0_0000);
    for (int i = 0; i < 20; i++) send_seg(directed[i]);
    idle_cycle();
    random_items(1000, 300, 600);

    // offset viewport with nan width and huge height
    set_viewport(1'b1, 32'h42C8_0000, 32'hC2C8_0000, QN, 32'h7F7F_FFFF);
    random_items(200, 0, -1);

    // degenerate sizes and extremes
    set_viewport(1'b1, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h43F0_0000);
    random_items(60, 0, -1);
    set_viewport(1'b1, 32'h0000_0001, Z0, 32'h4420_0000, 32'h8000_0000);
    random_items(60, 0, -1);
    set_viewport(1'b1, 32'hFF7F_FFFF, 32'h7FFF_FFFF, PINF, 32'h0000_0001);
    random_items(250, 0, -1);

    // disabled but sized viewport, then unit viewport
    set_viewport(1'b0, Z0, Z0, F_ONE, F_ONE);
    random_items(60, 0, -1);
    set_viewport(1'b1, Z0, Z0, F_ONE, F_ONE);
    random_items(300, 0, -1);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
